/* hdl/jhrl_pkg.sv */
// Package for the joint homing rate limiter core.
// Sizes, register indexes, command codes, reset values and state type.
// No dependencies.
`default_nettype none

package jhrl_pkg;

  // table geometry
  localparam int MAX_JOINTS = 32;
  localparam int POS_WIDTH  = 24;
  localparam int JIDX_W     = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;

  // fixed field widths
  localparam int CMD_W    = 2;
  localparam int JOINT_W  = 5;
  localparam int VALUE_W  = 24;
  localparam int PERIOD_W = 20;
  localparam int VEL_W    = 20;
  localparam int BAND_W   = 16;
  localparam int JCNT_W   = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // step limit: Q.16 * Q0.20 -> Q.36, rounded back to Q.16
  localparam int PROD_W    = VEL_W + PERIOD_W;
  localparam int STEP_SHIFT = 20;
  localparam int STEP_W    = PROD_W + 1 - STEP_SHIFT;
  // working width for differences and clamping
  localparam int CW = (POS_WIDTH + 1 > STEP_W + 1) ? POS_WIDTH + 1 : STEP_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRECISION_BAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JOINT_COUNT    = 2'd2;

  // reset values: 0.3 rad/s, 0.02 rad, all joints
  localparam logic [VEL_W-1:0]  RST_MAX_VELOCITY   = 20'd19661;
  localparam logic [BAND_W-1:0] RST_PRECISION_BAND = 16'd1311;
  localparam logic [JCNT_W-1:0] RST_JOINT_COUNT    = 6'd32;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HOME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POS  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_MOVE  = 3'b100
  } state_t;

endpackage

`default_nettype wire

/* hdl/joint_homing_rate_limiter_core.sv */
// Joint homing rate limiter core: home and position tables in RAM, goal test
// pass and, when needed, a rate-limited move pass per tick. Depends on jhrl_pkg.
`default_nettype none

// Command-style block. A word is taken when start is high and busy is low.
// Home (cmd 1) and position (cmd 2) writes give no result; cmd 3 is ignored.
// A tick (cmd 0) runs up to two passes over the active joints (joint_count,
// clamped to 1..MAX_JOINTS), each pass streaming one joint per cycle out of
// the table RAMs, which have registered reads. The first pass checks every
// joint against the precision band; if all are inside, one result word with
// at_goal and last set follows. Otherwise the second pass moves each position
// toward home by at most max_velocity * tick_period (rounded to Q.16), writes
// it back and reports one word per joint, in joint order, last on the final
// one. The final word is on the ports in the first cycle with busy low, so the
// next word can be taken at the edge that takes it. Result words sit on the
// output ports for exactly one cycle under result_strobe and must be taken
// there: the receiver cannot stall the block. Both tables read as zero after
// reset through per-entry valid flags, so there is no clearing pass.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while the block is idle, which the block does not enforce.
module joint_homing_rate_limiter_core
  import jhrl_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_data,
  // command
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [CMD_W-1:0]             cmd,
  input  wire logic [JOINT_W-1:0]           joint,
  input  wire logic signed [VALUE_W-1:0]    value,
  input  wire logic [PERIOD_W-1:0]          tick_period,
  // results
  output logic                              result_strobe,
  output logic [JOINT_W-1:0]                joint_index,
  output logic signed [VALUE_W-1:0]         reference,
  output logic                              at_goal,
  output logic                              last
);

  // configuration registers
  logic [VEL_W-1:0]  max_velocity;
  logic [BAND_W-1:0] precision_band;
  logic [JCNT_W-1:0] joint_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_velocity   <= RST_MAX_VELOCITY;
      precision_band <= RST_PRECISION_BAND;
      joint_count    <= RST_JOINT_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_VELOCITY:   max_velocity   <= cfg_data[VEL_W-1:0];
        REG_PRECISION_BAND: precision_band <= cfg_data[BAND_W-1:0];
        REG_JOINT_COUNT:    joint_count    <= cfg_data[JCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t              state;
  logic [JIDX_W-1:0]   rd_idx;      // next joint to read
  logic [JIDX_W-1:0]   last_idx;    // highest active joint of this tick
  logic                issuing;     // reads still to issue in this pass
  logic                rd_vld;      // read data of rd_tag is on the RAM outputs
  logic [JIDX_W-1:0]   rd_tag;
  logic                rd_last;
  logic                far;         // some joint outside the band so far
  logic [PERIOD_W-1:0] period;

  // step limit pipeline: period, then product, then rounded step, all registered
  logic [PROD_W-1:0]   prod;
  logic [STEP_W-1:0]   step;

  // accept decode
  logic accept;
  logic wr_home, wr_pos_cmd, joint_ok;
  int   n_act;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign joint_ok   = (32'(joint) < MAX_JOINTS);
  assign wr_home    = accept && (cmd == CMD_HOME) && joint_ok;
  assign wr_pos_cmd = accept && (cmd == CMD_POS) && joint_ok;

  always_comb begin
    n_act = int'(joint_count);
    if (n_act == 0) n_act = 1;
    if (n_act > MAX_JOINTS) n_act = MAX_JOINTS;
  end

  // table RAMs, with valid flags standing in for the reset clear
  logic signed [POS_WIDTH-1:0] home_mem [MAX_JOINTS];
  logic signed [POS_WIDTH-1:0] pos_mem  [MAX_JOINTS];
  logic [MAX_JOINTS-1:0]       home_vld, pos_vld;
  logic signed [POS_WIDTH-1:0] home_rd, pos_rd;
  logic                        home_rd_vld, pos_rd_vld;

  logic                        pos_we;
  logic [JIDX_W-1:0]           pos_waddr;
  logic signed [POS_WIDTH-1:0] pos_wdata;
  logic signed [POS_WIDTH-1:0] new_pos;
  logic                        move_wr;

  assign move_wr   = (state == S_MOVE) && rd_vld;
  assign pos_we    = wr_pos_cmd || move_wr;
  assign pos_waddr = move_wr ? rd_tag : JIDX_W'(joint);
  assign pos_wdata = move_wr ? new_pos : POS_WIDTH'(value);

  always_ff @(posedge clk) begin
    if (wr_home) home_mem[JIDX_W'(joint)] <= POS_WIDTH'(value);
    home_rd <= home_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rd <= pos_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_vld    <= '0;
      pos_vld     <= '0;
      home_rd_vld <= 1'b0;
      pos_rd_vld  <= 1'b0;
    end else begin
      if (wr_home) home_vld[JIDX_W'(joint)] <= 1'b1;
      if (pos_we)  pos_vld[pos_waddr]       <= 1'b1;
      home_rd_vld <= home_vld[rd_idx];
      pos_rd_vld  <= pos_vld[rd_idx];
    end
  end

  // per-joint datapath on the registered read data
  logic signed [CW-1:0] h_ext, p_ext, diff, diff_abs, step_s, delta;
  logic                 far_now;

  always_comb begin
    h_ext    = home_rd_vld ? CW'(home_rd) : '0;
    p_ext    = pos_rd_vld  ? CW'(pos_rd)  : '0;
    diff     = h_ext - p_ext;
    diff_abs = (diff < 0) ? -diff : diff;
    far_now  = (diff_abs > $signed(CW'(precision_band)));
    step_s   = $signed(CW'(step));
    if (diff > step_s)       delta = step_s;
    else if (diff < -step_s) delta = -step_s;
    else                     delta = diff;
    new_pos  = POS_WIDTH'(p_ext + delta);
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(max_velocity) * PROD_W'(period);
    step <= STEP_W'((PROD_W'(1) + prod + (PROD_W'(1) << (STEP_SHIFT - 1)) - PROD_W'(1))
                    >> STEP_SHIFT);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      rd_idx        <= '0;
      issuing       <= 1'b0;
      rd_vld        <= 1'b0;
      far           <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      rd_vld        <= issuing;
      rd_tag        <= rd_idx;
      rd_last       <= (rd_idx == last_idx);
      if (issuing) begin
        if (rd_idx == last_idx) issuing <= 1'b0;
        else rd_idx <= rd_idx + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd == CMD_TICK)) begin
            state    <= S_CHECK;
            period   <= tick_period;
            last_idx <= JIDX_W'(n_act - 1);
            rd_idx   <= '0;
            issuing  <= 1'b1;
            far      <= 1'b0;
          end
        end
        S_CHECK: begin
          if (rd_vld) begin
            far <= far || far_now;
            if (rd_last) begin
              if (far || far_now) begin
                // something to move: second pass
                state   <= S_MOVE;
                rd_idx  <= '0;
                issuing <= 1'b1;
              end else begin
                state         <= S_IDLE;
                result_strobe <= 1'b1;
                joint_index   <= '0;
                reference     <= '0;
                at_goal       <= 1'b1;
                last          <= 1'b1;
              end
            end
          end
        end
        S_MOVE: begin
          if (rd_vld) begin
            result_strobe <= 1'b1;
            joint_index   <= JOINT_W'(rd_tag);
            reference     <= VALUE_W'(new_pos);
            at_goal       <= 1'b0;
            last          <= rd_last;
            if (rd_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_goal_word: assert property (@(posedge clk) disable iff (rst)
    result_strobe && at_goal |-> last && (reference == '0) && (joint_index == '0))
    else $error("at_goal word malformed");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && last |-> !busy)
    else $error("block still busy after last word");

  a_move_reports: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE) && rd_vld |=> result_strobe && !at_goal)
    else $error("position write-back without result word");

  a_joint_order: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !last |=> result_strobe &&
      (joint_index == JOINT_W'($past(joint_index) + 1'b1)))
    else $error("result words out of joint order");
`endif

endmodule

`default_nettype wire
